FILE: rtl/core/tcl_pkg.sv
package tcl_pkg;

    localparam int unsigned PKT_BYTES = 3;

    typedef struct packed {
        logic [PKT_BYTES-1:0][7:0] bytes;
        logic [1:0]                cnt;
        logic                      last;
    } t_tcl_pkt;

    typedef struct packed {
        logic full;
        logic avail;
    } t_tcl_qstat;

endpackage

FILE: rtl/core/tcl_front.sv
module tcl_front
    import tcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_word_end,
    input  t_tcl_qstat i_qstat,
    output logic       o_push,
    output t_tcl_pkt   o_pkt
);

    function automatic logic [7:0] lookup_two(input logic [7:0] letter, input logic [7:0] digit);
        logic [7:0] upper;
        logic       lower;
        logic [7:0] res;
        logic [1:0] col;
        upper = letter;
        lower = 1'b0;
        res   = 8'h00;
        col   = 2'(digit - "1");
        if (letter >= "a" && letter <= "z") begin
            upper = letter - 8'h20;
            lower = 1'b1;
        end
        if (digit >= "1" && digit <= "4") begin
            unique case (upper)
                "A": begin
                    unique case (col)
                        2'd0: res = 8'hC1;
                        2'd1: res = 8'hC0;
                        2'd2: res = 8'hC2;
                        default: res = 8'hC4;
                    endcase
                end
                "E": begin
                    unique case (col)
                        2'd0: res = 8'hC9;
                        2'd1: res = 8'hC8;
                        2'd2: res = 8'hCA;
                        default: res = 8'hCB;
                    endcase
                end
                "I": begin
                    unique case (col)
                        2'd0: res = 8'hCD;
                        2'd1: res = 8'hCC;
                        2'd2: res = 8'hCE;
                        default: res = 8'hCF;
                    endcase
                end
                "O": begin
                    unique case (col)
                        2'd0: res = 8'hD3;
                        2'd1: res = 8'hD2;
                        2'd2: res = 8'hD4;
                        default: res = 8'hD6;
                    endcase
                end
                "U": begin
                    unique case (col)
                        2'd0: res = 8'hDA;
                        2'd1: res = 8'hD9;
                        2'd2: res = 8'hDB;
                        default: res = 8'hDC;
                    endcase
                end
                default: res = 8'h00;
            endcase
        end else if (digit == "5" && upper == "C") begin
            res = 8'hC7;
        end else if (digit == "6" && upper == "N") begin
            res = 8'hD1;
        end
        if (res != 8'h00 && lower) begin
            res = res + 8'h20;
        end
        return res;
    endfunction

    function automatic logic [7:0] lookup_three(input logic [7:0] first,
                                                input logic [7:0] second,
                                                input logic [7:0] digit);
        logic [7:0] res;
        res = 8'h00;
        if (digit == "7") begin
            if (first == "A" && second == "E") begin
                res = 8'hC6;
            end else if (first == "a" && second == "e") begin
                res = 8'hE6;
            end
        end else if (digit == "2" || digit == "4") begin
            if ((first == "s" && second == "s") || (first == "S" && second == "S") ||
                (first == "S" && second == "s")) begin
                res = 8'hDF;
            end
        end
        return res;
    endfunction

    logic [7:0] r_raw0, r_raw1, n_raw0, n_raw1;
    logic [1:0] r_pos, n_pos;
    logic [7:0] r_held0, r_held1, n_held0, n_held1;
    logic [1:0] r_held_cnt, n_held_cnt;

    logic [2:0][7:0] buf_b;
    logic [1:0]      buf_n;
    logic [7:0]      v2, v3;
    logic            is_code_digit;
    logic            done;
    logic            accept;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        v2            = lookup_two(r_raw0, i_char_in);
        v3            = lookup_three(r_raw1, r_raw0, i_char_in);
        is_code_digit = (i_char_in >= "0") && (i_char_in <= "9") && (r_pos != 2'd0);
        buf_b         = {8'h00, r_held1, r_held0};
        buf_n         = r_held_cnt;
        done          = 1'b0;

        if (is_code_digit && v2 != 8'h00) begin
            if (buf_n != 2'd0) begin
                buf_b[buf_n - 2'd1] = v2;
            end else begin
                buf_b[0] = v2;
                buf_n    = 2'd1;
            end
            done = 1'b1;
        end else if (is_code_digit && r_pos == 2'd2 && v3 != 8'h00) begin
            // held count never exceeds two, so the ligature always lands in slot zero
            buf_b[0] = v3;
            buf_n    = 2'd1;
            done     = 1'b1;
        end
        if (!done) begin
            buf_b[buf_n] = i_char_in;
            buf_n        = buf_n + 2'd1;
        end

        n_raw0     = r_raw0;
        n_raw1     = r_raw1;
        n_pos      = r_pos;
        n_held0    = r_held0;
        n_held1    = r_held1;
        n_held_cnt = r_held_cnt;
        o_push     = 1'b0;
        o_pkt      = '0;

        if (accept) begin
            if (i_word_end) begin
                n_raw0     = 8'h00;
                n_raw1     = 8'h00;
                n_pos      = 2'd0;
                n_held_cnt = 2'd0;
                o_push     = 1'b1;
                o_pkt.bytes = buf_b;
                o_pkt.cnt   = buf_n;
                o_pkt.last  = 1'b1;
            end else begin
                n_raw0 = i_char_in;
                n_raw1 = r_raw0;
                if (r_pos != 2'd2) begin
                    n_pos = r_pos + 2'd1;
                end
                if (buf_n == 2'd3) begin
                    o_push         = 1'b1;
                    o_pkt.bytes[0] = buf_b[0];
                    o_pkt.cnt      = 2'd1;
                    n_held0        = buf_b[1];
                    n_held1        = buf_b[2];
                    n_held_cnt     = 2'd2;
                end else begin
                    n_held0    = buf_b[0];
                    n_held1    = buf_b[1];
                    n_held_cnt = buf_n;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw0     <= 8'h00;
            r_raw1     <= 8'h00;
            r_pos      <= 2'd0;
            r_held_cnt <= 2'd0;
        end else begin
            r_raw0     <= n_raw0;
            r_raw1     <= n_raw1;
            r_pos      <= n_pos;
            r_held_cnt <= n_held_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held0 <= n_held0;
        r_held1 <= n_held1;
    end

    a_held_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt != 2'd3)
        else $error("held count above two");

    a_held_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt <= r_pos)
        else $error("more held bytes than bytes seen");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_pkt.cnt != 2'd0 && (o_pkt.last || o_pkt.cnt == 2'd1)))
        else $error("bad request size");

endmodule

FILE: rtl/core/tcl_queue.sv
module tcl_queue
    import tcl_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_tcl_pkt   i_pkt,
    output t_tcl_qstat o_qstat,
    input  logic       i_pop,
    output t_tcl_pkt   o_pkt
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_tcl_pkt        r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_qstat.full  = (r_count == CW'(DEPTH));
    assign o_qstat.avail = (r_count != '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && o_qstat.avail;
    assign o_pkt         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_qstat.full)
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_qstat.avail)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a push");

endmodule

FILE: rtl/core/tcl_back.sv
module tcl_back
    import tcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tcl_qstat i_qstat,
    input  t_tcl_pkt   i_pkt,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char_out,
    output logic       o_out_last
);

    t_tcl_pkt   r_pkt;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       at_end, adv, fin;

    assign at_end     = (r_idx == r_pkt.cnt - 2'd1);
    assign adv        = r_busy && i_ready;
    assign fin        = adv && at_end;
    assign o_pop      = i_qstat.avail && (!r_busy || fin);
    assign o_valid    = r_busy;
    assign o_char_out = r_pkt.bytes[r_idx];
    assign o_out_last = r_busy && r_pkt.last && at_end;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pkt <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (fin) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (adv) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_pkt.cnt))
        else $error("byte index past request size");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_last |-> (o_valid && at_end))
        else $error("last flag before final byte");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_busy || (i_ready && at_end)))
        else $error("request loaded over a busy one");

endmodule

FILE: rtl/core/telecode_to_latin1_decoder.sv
// channel   direction  handshake          payload
// input     in         i_valid / o_ready  i_char_in[7:0], i_word_end
// output    out        o_valid / i_ready  o_char_out[7:0], o_out_last
//
// one input byte accepted per cycle while the request queue has room
// a word end flushes up to three bytes, one per ready cycle out of the back end
// a request is registered in the queue, then in the back end, before it shows
// synchronous active-low reset clears history, counts, queue and output valid
// input stalls only when the queue is full; output stalls hold the back end alone
module telecode_to_latin1_decoder
    import tcl_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_word_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char_out,
    output logic       o_out_last
);

    t_tcl_qstat qstat;
    t_tcl_pkt   push_pkt, head_pkt;
    logic       push, pop;

    tcl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_char_in  (i_char_in),
        .i_word_end (i_word_end),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_pkt      (push_pkt)
    );

    tcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (push_pkt),
        .o_qstat (qstat),
        .i_pop   (pop),
        .o_pkt   (head_pkt)
    );

    tcl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (qstat),
        .i_pkt      (head_pkt),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char_out (o_char_out),
        .o_out_last (o_out_last)
    );

endmodule

FILE: dv/latin1_stream_checker.sv
`timescale 1ns / 100ps

module latin1_stream_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_word_end,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_char_out,
    input  logic       i_out_last,
    output int         o_pending,
    output int         o_err_count
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_latin1_byte;

    localparam logic [7:0] DIGIT_LOW  = "0";
    localparam logic [7:0] DIGIT_HIGH = "9";
    localparam logic [7:0] ACUTE      = "1";
    localparam logic [7:0] GRAVE      = "2";
    localparam logic [7:0] DIAERESIS  = "4";
    localparam logic [7:0] CEDILLA    = "5";
    localparam logic [7:0] TILDE      = "6";
    localparam logic [7:0] LIGATURE   = "7";
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [7:0] NO_CODE    = 8'h00;
    localparam logic [7:0] SHARP_S    = 8'hDF;
    localparam logic [7:0] AE_UPPER   = 8'hC6;
    localparam logic [7:0] AE_LOWER   = 8'hE6;
    localparam int         MAX_SHOWN  = 10;

    t_latin1_byte latin1_due_q[$];
    t_latin1_byte due_head;
    logic [7:0]   raw_prev [2];
    logic [1:0]   word_pos;
    logic [7:0]   held [2];
    logic [1:0]   held_cnt;
    int           err_count;

    // two-byte telecode: base letter followed by an accent digit
    function automatic logic [7:0] pair_code(logic [7:0] letter, logic [7:0] digit);
        logic        lower;
        logic [7:0]  base;
        logic [31:0] row;
        logic [7:0]  code;
        lower = (letter >= "a") && (letter <= "z");
        base  = lower ? letter - CASE_BIT : letter;
        code  = NO_CODE;
        if (digit >= ACUTE && digit <= DIAERESIS) begin
            row = '0;
            case (base)
                "A": row = {8'hC1, 8'hC0, 8'hC2, 8'hC4};
                "E": row = {8'hC9, 8'hC8, 8'hCA, 8'hCB};
                "I": row = {8'hCD, 8'hCC, 8'hCE, 8'hCF};
                "O": row = {8'hD3, 8'hD2, 8'hD4, 8'hD6};
                "U": row = {8'hDA, 8'hD9, 8'hDB, 8'hDC};
                default: row = '0;
            endcase
            code = row[8 * (3 - int'(digit - ACUTE)) +: 8];
        end else if (digit == CEDILLA && base == "C") begin
            code = 8'hC7;
        end else if (digit == TILDE && base == "N") begin
            code = 8'hD1;
        end
        if (code != NO_CODE && lower)
            code = code + CASE_BIT;
        return code;
    endfunction

    // three-byte telecode: ligature or sharp s
    function automatic logic [7:0] triple_code(logic [7:0] first, logic [7:0] second,
                                               logic [7:0] digit);
        if (digit == LIGATURE) begin
            if (first == "A" && second == "E")
                return AE_UPPER;
            if (first == "a" && second == "e")
                return AE_LOWER;
            return NO_CODE;
        end
        if (digit == GRAVE || digit == DIAERESIS) begin
            if ((first == "s" && second == "s") || (first == "S" && second == "S") ||
                (first == "S" && second == "s"))
                return SHARP_S;
        end
        return NO_CODE;
    endfunction

    task automatic decode_telecode_byte(input logic [7:0] c, input logic last);
        logic [7:0]   pend [3];
        int           n;
        int           emit;
        logic [7:0]   v;
        logic         done;
        t_latin1_byte item;
        n    = 0;
        done = 1'b0;
        for (int i = 0; i < held_cnt; i++) begin
            pend[n] = held[i];
            n++;
        end
        if (c >= DIGIT_LOW && c <= DIGIT_HIGH && word_pos >= 1) begin
            v = pair_code(raw_prev[0], c);
            if (v != NO_CODE) begin
                if (n > 0) begin
                    pend[n - 1] = v;
                end else begin
                    pend[n] = v;
                    n++;
                end
                done = 1'b1;
            end else if (word_pos >= 2) begin
                v = triple_code(raw_prev[1], raw_prev[0], c);
                if (v != NO_CODE) begin
                    n = (n >= 2) ? n - 2 : 0;
                    pend[n] = v;
                    n++;
                    done = 1'b1;
                end
            end
        end
        if (!done) begin
            pend[n] = c;
            n++;
        end
        raw_prev[1] = raw_prev[0];
        raw_prev[0] = c;
        if (word_pos < 2)
            word_pos++;
        if (last) begin
            for (int i = 0; i < n; i++) begin
                item.ch   = pend[i];
                item.last = (i == n - 1);
                latin1_due_q.push_back(item);
            end
            raw_prev[0] = '0;
            raw_prev[1] = '0;
            word_pos    = '0;
            held_cnt    = '0;
        end else begin
            emit = (n > 2) ? n - 2 : 0;
            for (int i = 0; i < emit; i++) begin
                item.ch   = pend[i];
                item.last = 1'b0;
                latin1_due_q.push_back(item);
            end
            for (int i = 0; i < n - emit; i++)
                held[i] = pend[emit + i];
            held_cnt = 2'(n - emit);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            latin1_due_q.delete();
            raw_prev[0] = '0;
            raw_prev[1] = '0;
            word_pos    = '0;
            held_cnt    = '0;
            err_count   = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (latin1_due_q.size() == 0) begin
                    if (err_count < MAX_SHOWN)
                        $display("unexpected output byte %02h last %0b",
                                 i_char_out, i_out_last);
                    err_count++;
                end else begin
                    due_head = latin1_due_q.pop_front();
                    if (i_char_out !== due_head.ch || i_out_last !== due_head.last) begin
                        if (err_count < MAX_SHOWN)
                            $display("output mismatch: expected %02h last %0b, got %02h last %0b",
                                     due_head.ch, due_head.last, i_char_out, i_out_last);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                decode_telecode_byte(i_char_in, i_word_end);
        end
        o_pending   <= latin1_due_q.size();
        o_err_count <= err_count;
    end

endmodule

FILE: dv/tb_telecode_to_latin1_decoder.sv
`timescale 1ns / 100ps

module tb_telecode_to_latin1_decoder;

    typedef enum logic [1:0] {
        PH_TX_SPARSE,
        PH_RX_SPARSE,
        PH_STREAM
    } t_phase;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;
    localparam int DRAIN_WAIT  = 20;

    logic       i_clk;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic       i_ready    = 1'b0;
    logic [7:0] i_char_in  = 8'h00;
    logic       i_word_end = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_char_out;
    logic       o_out_last;

    int     pending;
    int     err_count;
    int     cycle_count  = 0;
    int     bytes_offered = 0;
    int     tx_idle_pct  = 15;
    t_phase phase        = PH_TX_SPARSE;
    t_phase seen_phase   = PH_TX_SPARSE;
    int     hold_left    = 0;

    telecode_to_latin1_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_char_in  (i_char_in),
        .i_word_end (i_word_end),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char_out (o_char_out),
        .o_out_last (o_out_last)
    );

    latin1_stream_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_char_in   (i_char_in),
        .i_word_end  (i_word_end),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_char_out  (o_char_out),
        .i_out_last  (o_out_last),
        .o_pending   (pending),
        .o_err_count (err_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("telecode_to_latin1_decoder verification failed");
            $finish;
        end
    end

    // receiver side, with one long hold-off at the start of the streaming phase
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (phase != seen_phase) begin
            seen_phase <= phase;
            if (phase == PH_STREAM) begin
                i_ready   <= 1'b0;
                hold_left <= LONG_HOLD;
            end
        end else begin
            case (phase)
                PH_TX_SPARSE: i_ready <= ($urandom_range(99) >= 61);
                PH_RX_SPARSE: i_ready <= ($urandom_range(99) >= 15);
                default:      i_ready <= 1'b1;
            endcase
        end
    end

    task automatic offer_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_char_in  <= c;
        i_word_end <= last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        bytes_offered++;
    endtask

    task automatic offer_text(input string s);
        for (int i = 0; i < s.len(); i++)
            offer_byte(s[i], i == s.len() - 1);
    endtask

    task automatic offer_random_word();
        logic [7:0] word_q[$];
        int         segs;
        int         pick;
        logic [7:0] lower;
        string      vowels = "AEIOU";
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++) begin
            lower = $urandom_range(0, 1) ? 8'h20 : 8'h00;
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    pick = $urandom_range(0, 4);
                    word_q.push_back(8'(vowels[pick]) + lower);
                    word_q.push_back(8'("1") + 8'($urandom_range(0, 3)));
                end
                3: begin
                    word_q.push_back(8'("C") + lower);
                    word_q.push_back("5");
                end
                4: begin
                    word_q.push_back(8'("N") + lower);
                    word_q.push_back("6");
                end
                5: begin
                    word_q.push_back(8'("A") + lower);
                    word_q.push_back(8'("E") + lower);
                    word_q.push_back("7");
                end
                6: begin
                    pick = $urandom_range(0, 3);
                    word_q.push_back((pick == 0 || pick == 3) ? "s" : "S");
                    word_q.push_back((pick == 1 || pick == 3) ? "S" : "s");
                    word_q.push_back($urandom_range(0, 1) ? "2" : "4");
                end
                7: word_q.push_back(8'($urandom_range(0, 255)));
                8: word_q.push_back(8'("0") + 8'($urandom_range(0, 9)));
                default: word_q.push_back(8'("A") + 8'($urandom_range(0, 25)) + lower);
            endcase
        end
        // noise word
        if ($urandom_range(0, 4) == 0) begin
            word_q.delete();
            repeat ($urandom_range(1, 6))
                word_q.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < word_q.size(); i++)
            offer_byte(word_q[i], i == word_q.size() - 1);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer_text("1");
        offer_text("A1");
        offer_text("AE7");
        offer_text("ae7");
        offer_text("ss2");
        offer_text("SS4");
        offer_text("Ss2");
        offer_text("n6");
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h00, 1'b0);
        offer_byte("9", 1'b1);
        offer_text("q8");

        while (bytes_offered < 120)
            offer_random_word();
        wait_drained();

        tx_idle_pct = 61;
        phase <= PH_RX_SPARSE;
        while (bytes_offered < 215)
            offer_random_word();
        wait_drained();

        tx_idle_pct = 0;
        phase <= PH_STREAM;
        while (bytes_offered < 310)
            offer_random_word();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_count == 0 && pending == 0)
            $display("telecode_to_latin1_decoder verification clean");
        else
            $display("telecode_to_latin1_decoder verification failed");
        $finish;
    end

endmodule
